// ===== hw/rtl/lcps_pkg.sv =====
package lcps_pkg;

  // payload of the two channels
  typedef struct packed {
    logic              kind;
    logic signed [11:0] rho;
    logic [7:0]        theta_deg;
  } line_item_t;

  typedef struct packed {
    logic signed [6:0] steer_angle;
  } steer_item_t;

  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  // configuration register map
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd3;

  localparam logic [23:0] GAIN_P_RST      = 24'd6554;
  localparam logic [23:0] GAIN_I_RST      = 24'd655;
  localparam logic [23:0] GAIN_D_RST      = 24'd66;
  localparam logic [11:0] FRAME_WIDTH_RST = 12'd640;

  // fixed datapath widths
  localparam int GAIN_FRAC  = 16;
  localparam int TRIG_SHIFT = 14;
  localparam int SUM_W      = 32;
  localparam int INTEG_W    = 40;
  localparam int TOTAL_W    = 64;
  localparam int BASE_W     = 28;

  // shared bit-serial multiplier: signed a times unsigned b
  localparam int MUL_AW = 41;
  localparam int MUL_BW = 24;
  localparam int MUL_PW = MUL_AW + MUL_BW + 1;

  localparam logic [MUL_BW-1:0] HALF_LEN  = 24'd1000;
  localparam logic [MUL_BW-1:0] ANGLE_MUL = 24'd45;
  localparam logic signed [6:0] ANGLE_POS = 7'sd45;
  localparam logic signed [6:0] ANGLE_NEG = -7'sd45;

  localparam logic signed [MUL_PW-1:0] ITERM_HI =
    {{(MUL_PW-62){1'b0}}, 1'b1, {61{1'b0}}};
  localparam logic signed [MUL_PW-1:0] ITERM_LO = -ITERM_HI;

  typedef struct packed {
    logic                     start;
    logic signed [MUL_AW-1:0] a;
    logic [MUL_BW-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [MUL_PW-1:0] product;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LBASE,
    ST_LHALF,
    ST_LACC,
    ST_DIV,
    ST_ERR,
    ST_INTEG,
    ST_PID_P,
    ST_PID_I,
    ST_PID_D,
    ST_CLIP,
    ST_SCALE,
    ST_EMIT
  } state_t;

  // round(16384*sin(d)) for d = 0..90
  localparam logic [14:0] SINE_Q14 [0:90] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

endpackage

// ===== hw/rtl/lcps_stream_if.sv =====
interface lcps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lane_center_pid_steering.sv =====
// Lane-center PID steering. Line items (kind 0) carry a Hough line as rho and
// whole-degree theta; each one adds its two rounded endpoint x positions,
// round(rho*cos +- 1000*sin), to a running sum and bumps the line count, up to
// MAX_LINES lines per frame (later lines are dropped). An end-of-frame item
// (kind 1) divides the sum by twice the count for the lane center, takes the
// error against frame_width/2 with FRAC_BITS fraction bits, runs one PID step
// with Q8.16 gains, clamps the output to [-1,1], scales by 45 and sends the
// steering angle only when it is nonzero; an end of frame with no lines does
// nothing. One item is in work at a time. All products go through one shared
// bit-serial multiplier and the center through a bit-serial divider. A finished
// angle waits in an output register while the next items are taken.
module lane_center_pid_steering import lcps_pkg::*; #(
  parameter int MAX_LINES = 1024,
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  lcps_stream_if.sink          line_in,
  lcps_stream_if.source        steer_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CNT_W     = $clog2(MAX_LINES + 1);
  localparam int ERR_W     = FRAC_BITS + 13;
  localparam int DIVN_W    = SUM_W + FRAC_BITS;
  localparam int DIVD_W    = CNT_W + 1;
  localparam int CENTER_W  = DIVN_W + 1;
  localparam int ONE_SHIFT = FRAC_BITS + GAIN_FRAC;

  localparam logic signed [TOTAL_W-1:0] TOTAL_ONE     = TOTAL_W'(1) << ONE_SHIFT;
  localparam logic signed [TOTAL_W-1:0] TOTAL_NEG_ONE = -TOTAL_ONE;
  localparam logic [MUL_PW-1:0] SCALE_BIAS = (MUL_PW'(1) << ONE_SHIFT) - MUL_PW'(1);

  // configuration registers
  logic [23:0] gain_p, gain_i, gain_d;
  logic [11:0] frame_width;

  // frame and controller state
  logic signed [SUM_W-1:0]   endpoint_sum;
  logic [CNT_W-1:0]          line_count;
  logic signed [INTEG_W-1:0] error_integral;
  logic signed [ERR_W-1:0]   previous_error;

  // per-item working registers
  state_t                     state, state_next;
  logic signed [15:0]         sin_val;
  logic signed [BASE_W-1:0]   base;
  logic                       sum_neg;
  logic signed [CENTER_W-1:0] center;
  logic signed [ERR_W-1:0]    err;
  logic signed [TOTAL_W-1:0]  total;
  logic signed [6:0]          angle;

  // output register
  logic        out_valid;
  steer_item_t out_item;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  logic              div_start, div_done;
  logic [DIVN_W-1:0] div_quot;

  logic in_fire;
  logic count_full;

  assign in_fire    = line_in.valid && line_in.ready;
  assign count_full = line_count >= CNT_W'(MAX_LINES);
  // no item is taken while reset is held
  assign line_in.ready = !rst && (state == ST_IDLE);

  // trig lookup on the incoming angle; 180..255 folds back with both signs flipped
  logic [7:0]  deg, deg_fold, s_idx, c_idx;
  logic        flip, low_half, cos_neg;
  logic [14:0] s_mag, c_mag;
  logic signed [15:0] s_in;
  logic signed [12:0] rho_ext, rho_eff;

  always_comb begin
    deg      = line_in.data.theta_deg;
    flip     = deg >= 8'd180;
    deg_fold = flip ? deg - 8'd180 : deg;
    low_half = deg_fold <= 8'd90;
    s_idx    = low_half ? deg_fold : 8'd180 - deg_fold;
    c_idx    = low_half ? 8'd90 - deg_fold : deg_fold - 8'd90;
    s_mag    = SINE_Q14[s_idx[6:0]];
    c_mag    = SINE_Q14[c_idx[6:0]];
    cos_neg  = !low_half ^ flip;
    s_in     = flip ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
    rho_ext  = 13'(line_in.data.rho);
    // rho*cos as (+-rho)*|cos| so the multiplier operand stays unsigned
    rho_eff  = cos_neg ? -rho_ext : rho_ext;
  end

  // endpoint accumulation: base already carries the rounding half
  logic signed [BASE_W-1:0] half, v_lo, v_hi;
  logic signed [SUM_W-1:0]  e_lo, e_hi;

  always_comb begin
    half = $signed(mul_rsp.product[BASE_W-1:0]);
    v_lo = base - half;
    v_hi = base + half;
    e_lo = SUM_W'(v_lo >>> TRIG_SHIFT);
    e_hi = SUM_W'(v_hi >>> TRIG_SHIFT);
  end

  // divider operands, magnitude of the sum scaled to the error format
  logic [SUM_W-1:0]  sum_abs;
  logic [DIVN_W-1:0] div_num;
  logic [DIVD_W-1:0] div_den;

  assign sum_abs = endpoint_sum[SUM_W-1] ? SUM_W'(-endpoint_sum) : SUM_W'(endpoint_sum);
  assign div_num = {sum_abs, {FRAC_BITS{1'b0}}};
  assign div_den = {line_count, 1'b0};

  // error against half the frame width, saturated to ERR_W bits
  logic [CENTER_W-1:0]      target;
  logic signed [CENTER_W:0] err_full;
  logic                     err_ovf;
  logic signed [ERR_W-1:0]  err_sat;

  always_comb begin
    target   = CENTER_W'({frame_width[11:1], {FRAC_BITS{1'b0}}});
    err_full = $signed({center[CENTER_W-1], center}) - $signed({1'b0, target});
    err_ovf  = err_full[CENTER_W:ERR_W-1] != {(CENTER_W-ERR_W+2){err_full[CENTER_W]}};
    if (!err_ovf) begin
      err_sat = err_full[ERR_W-1:0];
    end else if (err_full[CENTER_W]) begin
      err_sat = {1'b1, {(ERR_W-1){1'b0}}};
    end else begin
      err_sat = {1'b0, {(ERR_W-1){1'b1}}};
    end
  end

  // integral update, saturated to INTEG_W bits
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_sat;

  always_comb begin
    integ_sum = $signed({error_integral[INTEG_W-1], error_integral}) + (INTEG_W+1)'(err);
    if (integ_sum[INTEG_W] == integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end else if (integ_sum[INTEG_W]) begin
      integ_sat = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      integ_sat = {1'b0, {(INTEG_W-1){1'b1}}};
    end
  end

  // integral term limit and final scaling (truncate toward zero)
  logic signed [MUL_PW-1:0] iterm_sat;
  logic signed [MUL_PW-1:0] scale_adj, scale_shr;
  logic signed [ERR_W:0]    err_diff;

  always_comb begin
    if (mul_rsp.product > ITERM_HI) begin
      iterm_sat = ITERM_HI;
    end else if (mul_rsp.product < ITERM_LO) begin
      iterm_sat = ITERM_LO;
    end else begin
      iterm_sat = mul_rsp.product;
    end
    scale_adj = mul_rsp.product +
                (mul_rsp.product[MUL_PW-1] ? $signed(SCALE_BIAS) : $signed(MUL_PW'(0)));
    scale_shr = scale_adj >>> ONE_SHIFT;
    err_diff  = (ERR_W+1)'(err) - (ERR_W+1)'(previous_error);
  end

  // sequencer: next state and unit launches
  always_comb begin
    state_next    = state;
    mul_req.start = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;
    div_start     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (line_in.data.kind == KIND_LINE) begin
            if (!count_full) begin
              mul_req.start = 1'b1;
              mul_req.a     = MUL_AW'(rho_eff);
              mul_req.b     = MUL_BW'(c_mag);
              state_next    = ST_LBASE;
            end
          end else if (line_count != '0) begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_LBASE: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_AW'(sin_val);
          mul_req.b     = HALF_LEN;
          state_next    = ST_LHALF;
        end
      end
      ST_LHALF: begin
        if (mul_rsp.done) begin
          state_next = ST_LACC;
        end
      end
      ST_LACC: state_next = ST_IDLE;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_ERR;
        end
      end
      ST_ERR: state_next = ST_INTEG;
      ST_INTEG: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_AW'(err);
        mul_req.b     = gain_p;
        state_next    = ST_PID_P;
      end
      ST_PID_P: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_AW'(error_integral);
          mul_req.b     = gain_i;
          state_next    = ST_PID_I;
        end
      end
      ST_PID_I: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_AW'(err_diff);
          mul_req.b     = gain_d;
          state_next    = ST_PID_D;
        end
      end
      ST_PID_D: begin
        if (mul_rsp.done) begin
          state_next = ST_CLIP;
        end
      end
      ST_CLIP: begin
        if (total >= TOTAL_ONE || total <= TOTAL_NEG_ONE) begin
          state_next = ST_EMIT;
        end else begin
          // inside (-1,1) the total fits the multiplier operand
          mul_req.start = 1'b1;
          mul_req.a     = total[MUL_AW-1:0];
          mul_req.b     = ANGLE_MUL;
          state_next    = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (mul_rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (angle == '0 || !out_valid || steer_out.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p      <= GAIN_P_RST;
      gain_i      <= GAIN_I_RST;
      gain_d      <= GAIN_D_RST;
      frame_width <= FRAME_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_P:      gain_p      <= cfg_data;
        CFG_GAIN_I:      gain_i      <= cfg_data;
        CFG_GAIN_D:      gain_d      <= cfg_data;
        CFG_FRAME_WIDTH: frame_width <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // frame accumulators and PID memory
  always_ff @(posedge clk) begin
    if (rst) begin
      endpoint_sum   <= '0;
      line_count     <= '0;
      error_integral <= '0;
      previous_error <= '0;
    end else begin
      if (state == ST_LACC) begin
        endpoint_sum <= endpoint_sum + e_lo + e_hi;
        line_count   <= line_count + 1'b1;
      end
      if (state == ST_INTEG) begin
        error_integral <= integ_sat;
      end
      if (state == ST_PID_D && mul_rsp.done) begin
        previous_error <= err;
        endpoint_sum   <= '0;
        line_count     <= '0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire) begin
      sin_val <= s_in;
      sum_neg <= endpoint_sum[SUM_W-1];
    end
    if (state == ST_LBASE && mul_rsp.done) begin
      base <= $signed(mul_rsp.product[BASE_W-1:0]) + BASE_W'(1 << (TRIG_SHIFT - 1));
    end
    if (state == ST_DIV && div_done) begin
      center <= sum_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    end
    if (state == ST_ERR) begin
      err <= err_sat;
    end
    if (mul_rsp.done) begin
      unique case (state)
        ST_PID_P: total <= mul_rsp.product[TOTAL_W-1:0];
        ST_PID_I: total <= total + TOTAL_W'(iterm_sat);
        ST_PID_D: total <= total + mul_rsp.product[TOTAL_W-1:0];
        ST_SCALE: angle <= scale_shr[6:0];
        default: ;
      endcase
    end
    if (state == ST_CLIP) begin
      if (total >= TOTAL_ONE) begin
        angle <= ANGLE_POS;
      end else if (total <= TOTAL_NEG_ONE) begin
        angle <= ANGLE_NEG;
      end
    end
  end

  // output register, loaded when the slot is free or being emptied
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && angle != '0 && (!out_valid || steer_out.ready)) begin
      out_valid <= 1'b1;
    end else if (steer_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && angle != '0 && (!out_valid || steer_out.ready)) begin
      out_item.steer_angle <= angle;
    end
  end

  assign steer_out.valid = out_valid;
  assign steer_out.data  = out_item;

  lcps_mul_serial u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  lcps_div_serial #(
    .NUM_W (DIVN_W),
    .DEN_W (DIVD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quot)
  );

  // a zero angle is never sent
  a_out_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.steer_angle != '0)
    else $error("zero steering angle on output");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.steer_angle <= ANGLE_POS && out_item.steer_angle >= ANGLE_NEG))
    else $error("steering angle out of range");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    line_count <= CNT_W'(MAX_LINES))
    else $error("line count past cap");

  a_eof_starts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && line_in.data.kind == KIND_EOF && line_count != '0) |=> state == ST_DIV)
    else $error("end of frame did not start the divider");

  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == ST_LBASE || state == ST_LHALF || state == ST_PID_P ||
                      state == ST_PID_I || state == ST_PID_D || state == ST_SCALE))
    else $error("multiplier finished with no waiting step");

endmodule

// ===== hw/rtl/lcps_mul_serial.sv =====
module lcps_mul_serial import lcps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CNT_W = $clog2(MUL_BW);

  logic signed [MUL_AW-1:0] a_reg;
  logic signed [MUL_AW:0]   hi;
  logic [MUL_BW-1:0]        lo;
  logic [CNT_W-1:0]         cnt;
  logic                     busy;
  logic                     done;
  logic signed [MUL_AW:0]   partial;

  // one multiplier bit per cycle, lsb first
  assign partial = hi + (lo[0] ? {a_reg[MUL_AW-1], a_reg} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= req.a;
      hi    <= '0;
      lo    <= req.b;
    end else if (busy) begin
      hi <= {partial[MUL_AW], partial[MUL_AW:1]};
      lo <= {partial[0], lo[MUL_BW-1:1]};
    end
  end

  assign rsp.done    = done;
  assign rsp.product = {hi, lo};

endmodule

// ===== hw/rtl/lcps_div_serial.sv =====
module lcps_div_serial #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] shreg;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, shreg[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      den   <= divisor;
    end else if (busy) begin
      shreg <= {shreg[NUM_W-2:0], fits};
      rem   <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    end
  end

  assign quotient = shreg;

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import lcps_pkg::*;

  localparam int MAX_LINES = 1024;
  localparam int FRAC_BITS = 8;

  // settle time before a register write or the verdict; an end of frame
  // that saturates or emits nothing leaves no result to wait for
  localparam int SETTLE_CYCLES = 200;

  // fixed point limits of the steering law
  localparam longint ERR_LIM   = 64'sd1 <<< (FRAC_BITS + 12);
  localparam longint INTEG_LIM = 64'sd1 <<< 39;
  localparam longint ITERM_LIM = 64'sd1 <<< 61;
  localparam longint UNITY     = 64'sd1 <<< (FRAC_BITS + 16);
  localparam longint MAX_STEER = 45;

  // round(16384*sin(d)), d = 0..90, kept apart from the design's own table
  localparam longint sin_tab [0:90] = '{
    0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
    2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
    5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
    8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  lcps_stream_if #(.payload_t(line_item_t))  line_if ();
  lcps_stream_if #(.payload_t(steer_item_t)) steer_if ();

  lane_center_pid_steering #(
    .MAX_LINES(MAX_LINES),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .line_in   (line_if),
    .steer_out (steer_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // copy of the register file as the design should hold it
  logic [23:0] kp = GAIN_P_RST;
  logic [23:0] ki = GAIN_I_RST;
  logic [23:0] kd = GAIN_D_RST;
  logic [11:0] fw_px = FRAME_WIDTH_RST;

  // controller state as the design should hold it
  longint ep_sum    = 0;
  int     n_lines   = 0;
  longint err_integ = 0;
  longint last_err  = 0;

  // angles still owed by the design, oldest first
  logic signed [6:0] pending_angles [$];

  int n_fail       = 0;
  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;
  int hold_left    = 0;

  function automatic longint round_q14(input longint v);
    // floor(v/2^14 + 1/2): arithmetic shift floors negative values too
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // advances the controller by one item; returns 1 when an angle goes out
  function automatic bit predict_steer(input line_item_t item,
                                       output logic signed [6:0] angle);
    longint rho_v, sin_v, cos_v, base, half;
    longint center, err, pterm, iterm, dterm, total, scaled;
    int deg;
    bit flip;
    angle = '0;
    if (item.kind == KIND_LINE) begin
      // lines past the per-frame limit are dropped
      if (n_lines >= MAX_LINES) return 1'b0;
      rho_v = longint'($signed(item.rho));
      deg = int'(item.theta_deg);
      // angles past 179 fold back with both sine and cosine negated
      flip = (deg >= 180);
      if (flip) deg -= 180;
      if (deg <= 90) begin
        sin_v = sin_tab[deg];
        cos_v = sin_tab[90 - deg];
      end else begin
        sin_v = sin_tab[180 - deg];
        cos_v = -sin_tab[deg - 90];
      end
      if (flip) begin
        sin_v = -sin_v;
        cos_v = -cos_v;
      end
      base = rho_v * cos_v;
      half = 1000 * sin_v;
      ep_sum += round_q14(base - half) + round_q14(base + half);
      n_lines++;
      return 1'b0;
    end
    // end of frame with no lines: nothing happens at all
    if (n_lines == 0) return 1'b0;
    center = (ep_sum <<< FRAC_BITS) / (2 * longint'(n_lines));
    err = clip(center - (longint'(fw_px >> 1) <<< FRAC_BITS), -ERR_LIM, ERR_LIM - 1);
    err_integ = clip(err_integ + err, -INTEG_LIM, INTEG_LIM - 1);
    pterm = longint'(kp) * err;
    iterm = clip(longint'(ki) * err_integ, -ITERM_LIM, ITERM_LIM);
    dterm = longint'(kd) * (err - last_err);
    total = pterm + iterm + dterm;
    last_err = err;
    ep_sum = 0;
    n_lines = 0;
    if (total >= UNITY) scaled = MAX_STEER;
    else if (total <= -UNITY) scaled = -MAX_STEER;
    else scaled = (total * MAX_STEER) / UNITY;
    angle = scaled[6:0];
    return scaled != 0;
  endfunction

  function automatic line_item_t mk_item(input logic kind, input int rho, input int theta);
    line_item_t it;
    it.kind = kind;
    it.rho = rho[11:0];
    it.theta_deg = theta[7:0];
    return it;
  endfunction

  // random line with extra weight on the rho extremes; one in eight takes a folded angle
  function automatic line_item_t rand_line();
    int r;
    int th;
    case ($urandom_range(0, 7))
      0:       r = -2048;
      1:       r = 2047;
      default: r = int'($urandom_range(0, 4095)) - 2048;
    endcase
    if ($urandom_range(0, 7) == 0) th = int'($urandom_range(180, 255));
    else th = int'($urandom_range(0, 179));
    return mk_item(KIND_LINE, r, th);
  endfunction

  function automatic logic [23:0] pick_gain();
    logic [31:0] r;
    case ($urandom_range(0, 4))
      0:       r = 32'd0;
      1:       r = 32'hFFFFFF;
      2:       r = $urandom_range(0, 4096);
      3:       r = $urandom_range(0, 1 << 17);
      default: r = $urandom;
    endcase
    return r[23:0];
  endfunction

  function automatic logic [11:0] pick_width();
    case ($urandom_range(0, 5))
      0:       return 12'd1;
      1:       return 12'd4095;
      default: return 12'($urandom_range(1, 4095));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    n_fail++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // offers one item and returns at the edge that takes it; valid stays
  // high so that back-to-back items need no second assignment in a step
  task automatic send_item(input line_item_t item);
    logic [31:0] noise;
    logic taken;
    logic signed [6:0] a;
    if (src_idle_on && $urandom_range(0, 99) < 29) begin
      noise = $urandom;
      line_if.valid <= 1'b0;
      line_if.data  <= noise[$bits(line_item_t)-1:0];
      @(posedge clk);
      while ($urandom_range(0, 99) < 29) @(posedge clk);
    end
    line_if.valid <= 1'b1;
    line_if.data  <= item;
    do begin
      @(negedge clk);
      taken = line_if.ready;
      @(posedge clk);
    end while (!taken);
    if (predict_steer(item, a)) pending_angles.push_back(a);
  endtask

  task automatic send_frame(input int lines);
    repeat (lines) send_item(rand_line());
    // the line fields of an end of frame are noise
    send_item(mk_item(KIND_EOF, int'($urandom_range(0, 4095)), int'($urandom_range(0, 255))));
  endtask

  // mostly short frames, some long ones, now and then an empty one
  task automatic run_batch(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 11))
        0:       len = 0;
        1:       len = int'($urandom_range(7, 40));
        default: len = int'($urandom_range(1, 6));
      endcase
      send_frame(len);
      sent += len + 1;
    end
  endtask

  // stop offering, collect every owed angle, then let the datapath go quiet
  task automatic wait_idle();
    line_if.valid <= 1'b0;
    do @(negedge clk); while (pending_angles.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [23:0] gp, input logic [23:0] gi,
                                input logic [23:0] gd, input logic [11:0] fw);
    logic [CFG_W-1:0]     vals [4];
    logic [CFG_IDX_W-1:0] idxs [4];
    wait_idle();
    vals = '{gp, gi, gd, {12'd0, fw}};
    idxs = '{CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D, CFG_FRAME_WIDTH};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[k];
      cfg_data  <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    kp = gp;
    ki = gi;
    kd = gd;
    fw_px = fw;
  endtask

  // hand-picked items under the reset gains
  task automatic test_directed();
    // empty frame right after reset, with junk line fields
    send_item(mk_item(KIND_EOF, -1, 255));
    // line dead on the target: zero error, zero angle, nothing sent
    send_item(mk_item(KIND_LINE, 320, 0));
    send_item(mk_item(KIND_EOF, 0, 0));
    // rho extremes at 0 and 90 degrees
    send_item(mk_item(KIND_LINE, 2047, 0));
    send_item(mk_item(KIND_LINE, -2048, 90));
    send_item(mk_item(KIND_EOF, 2047, 179));
    // top of the nominal angle range and the folded angles above it
    send_item(mk_item(KIND_LINE, -2048, 179));
    send_item(mk_item(KIND_LINE, 2047, 180));
    send_item(mk_item(KIND_LINE, -1, 255));
    send_item(mk_item(KIND_LINE, 0, 45));
    send_item(mk_item(KIND_EOF, -2048, 128));
    // second empty frame, this time after a real one
    send_item(mk_item(KIND_EOF, 1, 1));
    // just past 90 degrees, where cosine turns negative
    send_item(mk_item(KIND_LINE, -2048, 0));
    send_item(mk_item(KIND_LINE, 1, 91));
    send_item(mk_item(KIND_LINE, 1000, 89));
    send_item(mk_item(KIND_EOF, 0, 0));
    // small rho just off the target; the integral left by the earlier frames still holds the output on the clamp
    send_item(mk_item(KIND_LINE, 321, 0));
    send_item(mk_item(KIND_EOF, 0, 0));
  endtask

  // each register at both ends of its range
  task automatic test_register_extremes();
    apply_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 12'd4095);
    run_batch(5);
    apply_settings(24'd0, 24'd0, 24'd0, 12'd1);
    run_batch(5);
    apply_settings(24'hFFFFFF, 24'd0, 24'd0, 12'd1);
    run_batch(5);
    apply_settings(24'd0, 24'hFFFFFF, 24'd0, 12'd4095);
    run_batch(5);
    apply_settings(24'd0, 24'd0, 24'hFFFFFF, 12'd640);
    run_batch(5);
  endtask

  // random settings per batch; one longer batch runs with no idling at all
  task automatic test_random_settings();
    for (int b = 0; b < 7; b++) begin
      apply_settings(pick_gain(), pick_gain(), pick_gain(), pick_width());
      src_idle_on  = (b != 2);
      sink_idle_on = (b != 2);
      run_batch((b == 2) ? 30 : 5);
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // more lines than a frame may hold, then a short frame to show the clear
  task automatic test_line_limit();
    send_frame(MAX_LINES + 2);
    send_frame(3);
  endtask

  // receiver holds off while short frames keep coming, so the output
  // register fills and the design has to stall its input
  task automatic test_output_stall();
    apply_settings(24'h010000, 24'd0, 24'd0, 12'd640);
    @(negedge clk);
    hold_left = 2000;
    @(posedge clk);
    repeat (12) send_frame(1);
  endtask

  // receiver: random stalls, or a long counted hold when one is requested
  initial begin
    steer_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        steer_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        steer_if.ready <= 1'b0;
      end else begin
        steer_if.ready <= !(sink_idle_on && $urandom_range(0, 99) < 29);
      end
    end
  end

  // outputs are stable between edges, so the handshake is sampled mid-cycle
  always @(negedge clk) begin : check_angle
    logic signed [6:0] got;
    logic signed [6:0] want;
    if (!rst && steer_if.valid && steer_if.ready) begin
      got = steer_if.data.steer_angle;
      if (pending_angles.size() == 0) begin
        report_mismatch($sformatf("steering angle %0d with none owed", got));
      end else begin
        want = pending_angles.pop_front();
        if (got !== want)
          report_mismatch($sformatf("steer_angle %0d, owed %0d", got, want));
      end
    end
  end

  initial begin
    line_if.valid <= 1'b0;
    line_if.data  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_register_extremes();
    test_random_settings();
    test_line_limit();
    test_output_stall();

    wait_idle();
    if (n_fail == 0) begin
      $display("lane_center_pid_steering regression: pass");
    end else begin
      $display("lane_center_pid_steering regression: fail");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #20_000_000;
    $display("lane_center_pid_steering regression: fail");
    $finish;
  end

endmodule
